### src/hgsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgsg_pkg
// Shared types, constants and saturation helpers of the helix setpoint block.
// ----------------------------------------------------------------------------
package hgsg_pkg;

   localparam int TICK_RATE_HZ = 4;
   localparam int COORD_BITS   = 32;
   localparam int TICK_BITS    = $clog2(TICK_RATE_HZ + 1);
   localparam int DEN_W        = 33 + TICK_BITS;
   localparam int ROOT_STEPS   = 32;
   localparam int DIV_STEPS    = 64;

   typedef logic signed [63:0]           wide_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam wide_type TOL_RAW        = 64'sd655360;
   localparam wide_type MIN_RADIUS_RAW = 64'sd3276800;
   localparam wide_type ONE_RAW        = 64'sd65536;
   localparam wide_type TENTH_RAW      = 64'sd6553;
   localparam wide_type MILLI_RAW      = 64'sd65;
   localparam wide_type S32_MAX        = 64'sd2147483647;
   localparam wide_type S32_MIN        = -64'sd2147483648;
   localparam wide_type COORD_MAX      = wide_type'((64'd1 << (COORD_BITS - 1)) - 64'd1);
   localparam wide_type COORD_MIN      = -COORD_MAX - 64'sd1;

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_CIRCLE = 2'd1;
   localparam logic [1:0] PH_FAIL   = 2'd2;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_SETUP  = 3'd1;
   localparam logic [2:0] OP_CENTRE = 3'd2;
   localparam logic [2:0] OP_HSPEED = 3'd3;
   localparam logic [2:0] OP_VSPEED = 3'd4;

   localparam logic [2:0] REG_START_ALT = 3'd0;
   localparam logic [2:0] REG_STOP_ALT  = 3'd1;
   localparam logic [2:0] REG_START_RAD = 3'd2;
   localparam logic [2:0] REG_STOP_RAD  = 3'd3;
   localparam logic [2:0] REG_VEL_EAST  = 3'd4;
   localparam logic [2:0] REG_VEL_NORTH = 3'd5;
   localparam logic [2:0] REG_VEL_UP    = 3'd6;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] pos_east;
      logic signed [31:0] pos_north;
      logic signed [31:0] pos_altitude;
      logic signed [31:0] new_center_east;
      logic signed [31:0] new_center_north;
      logic signed [31:0] new_speed_east;
      logic signed [31:0] new_speed_north;
      logic signed [31:0] new_speed_up;
   } req_type;

   typedef struct packed {
      logic               active;
      logic               failed;
      logic signed [31:0] circle_east;
      logic signed [31:0] circle_north;
      logic signed [31:0] circle_radius;
      logic signed [31:0] target_altitude;
      logic signed [31:0] climb_rate;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] data;
   } csr_type;

   typedef struct packed {
      logic latch;
      logic diff;
      logic sqx;
      logic sqy;
      logic sum;
      logic root;
      logic eval;
      logic mulr;
      logic dinit;
      logic dstep;
      logic dfin;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic tick;
      logic setup_div;
   } stat_type;

   function automatic wide_type mag(input wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = S32_MAX[31:0];
      else if (v < S32_MIN) r = S32_MIN[31:0];
      else r = v[31:0];
      return r;
   endfunction

   function automatic coord_type satc(input wide_type v);
      coord_type r;
      if (v > COORD_MAX) r = COORD_MAX[COORD_BITS-1:0];
      else if (v < COORD_MIN) r = COORD_MIN[COORD_BITS-1:0];
      else r = v[COORD_BITS-1:0];
      return r;
   endfunction

endpackage

### src/hgsg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgsg_if
// Valid/ready channels of the helix setpoint block: request, result, csr.
// ----------------------------------------------------------------------------
interface hgsg_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [31:0] pos_east;
   logic signed [31:0] pos_north;
   logic signed [31:0] pos_altitude;
   logic signed [31:0] new_center_east;
   logic signed [31:0] new_center_north;
   logic signed [31:0] new_speed_east;
   logic signed [31:0] new_speed_north;
   logic signed [31:0] new_speed_up;

   modport source (output valid, opcode, pos_east, pos_north, pos_altitude,
                   new_center_east, new_center_north, new_speed_east,
                   new_speed_north, new_speed_up, input ready);
   modport sink (input valid, opcode, pos_east, pos_north, pos_altitude,
                 new_center_east, new_center_north, new_speed_east,
                 new_speed_north, new_speed_up, output ready);
endinterface

interface hgsg_rsp_if;
   logic               valid;
   logic               ready;
   logic               active;
   logic               failed;
   logic signed [31:0] circle_east;
   logic signed [31:0] circle_north;
   logic signed [31:0] circle_radius;
   logic signed [31:0] target_altitude;
   logic signed [31:0] climb_rate;

   modport source (output valid, active, failed, circle_east, circle_north,
                   circle_radius, target_altitude, climb_rate, input ready);
   modport sink (input valid, active, failed, circle_east, circle_north,
                 circle_radius, target_altitude, climb_rate, output ready);
endinterface

interface hgsg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/hgsg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgsg_ctrl
// Sequencer: accepts a request, steps the datapath through distance, square
// root for ticks, evaluation and optional division, then hands the result out.
// ----------------------------------------------------------------------------
module hgsg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hgsg_pkg::cmd_type  cmd,
   input  hgsg_pkg::stat_type stat
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_SQX   = 4'd2;
   localparam logic [3:0] S_SQY   = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_ROOT  = 4'd5;
   localparam logic [3:0] S_EVAL  = 4'd6;
   localparam logic [3:0] S_MULR  = 4'd7;
   localparam logic [3:0] S_DINIT = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DFIN  = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = stat.tick ? S_SQX : S_EVAL;
         end
         S_SQX: begin
            cmd.sqx  = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sqy  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root = 1'b1;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'(hgsg_pkg::ROOT_STEPS - 1)) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stat.setup_div ? S_MULR : S_EMIT;
         end
         S_MULR: begin
            cmd.mulr = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.dinit = 1'b1;
            cnt_in    = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.dstep = 1'b1;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'(hgsg_pkg::DIV_STEPS - 1)) state_in = S_DFIN;
         end
         S_DFIN: begin
            cmd.dfin = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/hgsg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgsg_dp
// Datapath: configuration and guidance state, distance multiplier, bit-serial
// square root, radix-2 divider for the radius increment and result register.
// ----------------------------------------------------------------------------
module hgsg_dp (
   input  logic               clock,
   input  logic               reset,
   input  hgsg_pkg::cmd_type  cmd,
   output hgsg_pkg::stat_type stat,
   input  hgsg_pkg::req_type  req_data,
   input  logic               csr_we,
   input  hgsg_pkg::csr_type  csr_data,
   output hgsg_pkg::rsp_type  rsp_data
);

   typedef struct packed {
      logic signed [31:0] start_alt;
      logic signed [31:0] stop_alt;
      logic [30:0]        start_rad;
      logic [30:0]        stop_rad;
      logic signed [31:0] vel_e;
      logic signed [31:0] vel_n;
      logic signed [31:0] vel_u;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          phase;
      hgsg_pkg::coord_type cpos_e;
      hgsg_pkg::coord_type cpos_n;
      hgsg_pkg::coord_type cpos_a;
      logic signed [31:0]  step_e;
      logic signed [31:0]  step_n;
      logic signed [31:0]  step_a;
      logic signed [31:0]  cur_rad;
      logic signed [31:0]  cl_start;
      logic signed [31:0]  cl_stop;
      logic signed [31:0]  rstep;
      logic signed [31:0]  held_start;
      logic signed [31:0]  held_stop;
   } state_type;

   cfg_type                  cfg_ff, cfg_in;
   state_type                st_ff, st_in;
   hgsg_pkg::req_type        req_ff, req_in;
   hgsg_pkg::rsp_type        rsp_ff, rsp_in;
   logic [31:0]              ax_ff, ax_in, ay_ff, ay_in;
   logic                     big_ff, big_in, ovf_ff, ovf_in;
   logic [63:0]              sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [63:0]              n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   hgsg_pkg::wide_type       prod_ff, prod_in;
   logic [63:0]              quo_ff, quo_in;
   logic [hgsg_pkg::DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic                     neg_ff, neg_in, act_ff, act_in;
   logic signed [31:0]       climb_ff, climb_in;

   hgsg_pkg::wide_type dx, dy, dz_w, dr_w, vz_w, vq, dist_w, q_w;
   logic [64:0]        sum65;
   logic [63:0]        trial_r;
   logic [hgsg_pkg::DEN_W:0] trial_d;
   logic [31:0]        dist_raw;
   logic               sign_bad, dr_small, dz_small, vz_big;
   logic               near_start, near_stop_r, near_stop_a;
   logic signed [31:0] cl_start_v, cl_stop_v;

   assign dz_w = hgsg_pkg::wide_type'(cfg_ff.stop_alt) - hgsg_pkg::wide_type'(cfg_ff.start_alt);
   assign dr_w = hgsg_pkg::wide_type'(cfg_ff.stop_rad) - hgsg_pkg::wide_type'(cfg_ff.start_rad);
   assign vz_w = hgsg_pkg::wide_type'(cfg_ff.vel_u);
   assign vq   = vz_w / hgsg_pkg::TICK_RATE_HZ;

   assign dr_small = hgsg_pkg::mag(dr_w) < hgsg_pkg::ONE_RAW;
   assign dz_small = hgsg_pkg::mag(dz_w) < hgsg_pkg::ONE_RAW;
   assign vz_big   = hgsg_pkg::mag(vz_w) > hgsg_pkg::TENTH_RAW;
   assign sign_bad = ((dz_w < 0 && vz_w > 0) || (dz_w > 0 && vz_w < 0)) &&
                     hgsg_pkg::mag(dz_w) > hgsg_pkg::ONE_RAW &&
                     hgsg_pkg::mag(dr_w) > hgsg_pkg::TENTH_RAW;

   assign stat.tick      = (req_ff.opcode == hgsg_pkg::OP_TICK);
   assign stat.setup_div = (req_ff.opcode == hgsg_pkg::OP_SETUP) && !sign_bad && !dr_small &&
                           !(dz_small && vz_big) && vz_big && (dz_w != 0);

   assign cl_start_v = (hgsg_pkg::wide_type'(cfg_ff.start_rad) < hgsg_pkg::MIN_RADIUS_RAW) ?
                       hgsg_pkg::MIN_RADIUS_RAW[31:0] : {1'b0, cfg_ff.start_rad};
   assign cl_stop_v  = (hgsg_pkg::wide_type'(cfg_ff.stop_rad) < hgsg_pkg::MIN_RADIUS_RAW) ?
                       hgsg_pkg::MIN_RADIUS_RAW[31:0] : {1'b0, cfg_ff.stop_rad};

   // distance to the centre, capped
   assign dist_raw = (ovf_ff || big_ff) ? 32'hFFFF_FFFF : r_ff[31:0];
   assign dist_w   = hgsg_pkg::wide_type'(dist_raw);

   assign near_start  = hgsg_pkg::mag(dist_w - hgsg_pkg::wide_type'(st_ff.cl_start)) <
                        hgsg_pkg::TOL_RAW &&
                        hgsg_pkg::mag(hgsg_pkg::wide_type'(req_ff.pos_altitude) -
                        hgsg_pkg::wide_type'(st_ff.held_start)) < hgsg_pkg::TOL_RAW;
   assign near_stop_r = hgsg_pkg::mag(dist_w - hgsg_pkg::wide_type'(st_ff.cl_stop)) <
                        hgsg_pkg::TOL_RAW;
   assign near_stop_a = hgsg_pkg::mag(hgsg_pkg::wide_type'(req_ff.pos_altitude) -
                        hgsg_pkg::wide_type'(st_ff.held_stop)) < hgsg_pkg::TOL_RAW;

   assign dx      = hgsg_pkg::wide_type'(req_ff.pos_east) - hgsg_pkg::wide_type'(st_ff.cpos_e);
   assign dy      = hgsg_pkg::wide_type'(req_ff.pos_north) - hgsg_pkg::wide_type'(st_ff.cpos_n);
   assign sum65   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign trial_r = r_ff + bit_ff;
   assign trial_d = {rem_ff, quo_ff[63]};
   assign q_w     = hgsg_pkg::wide_type'(quo_ff);

   always_comb begin
      cfg_in   = cfg_ff;
      st_in    = st_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      big_in   = big_ff;
      ovf_in   = ovf_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      act_in   = act_ff;
      climb_in = climb_ff;

      if (csr_we) begin
         unique case (csr_data.index)
            hgsg_pkg::REG_START_ALT: cfg_in.start_alt = csr_data.data;
            hgsg_pkg::REG_STOP_ALT:  cfg_in.stop_alt  = csr_data.data;
            hgsg_pkg::REG_START_RAD: cfg_in.start_rad = csr_data.data[30:0];
            hgsg_pkg::REG_STOP_RAD:  cfg_in.stop_rad  = csr_data.data[30:0];
            hgsg_pkg::REG_VEL_EAST:  cfg_in.vel_e     = csr_data.data;
            hgsg_pkg::REG_VEL_NORTH: cfg_in.vel_n     = csr_data.data;
            hgsg_pkg::REG_VEL_UP:    cfg_in.vel_u     = csr_data.data;
            default: ;
         endcase
      end

      if (cmd.latch) req_in = req_data;

      if (cmd.diff) begin
         big_in = (hgsg_pkg::mag(dx) > 64'sd4294967295) ||
                  (hgsg_pkg::mag(dy) > 64'sd4294967295);
         ax_in  = 32'(hgsg_pkg::mag(dx));
         ay_in  = 32'(hgsg_pkg::mag(dy));
      end

      if (cmd.sqx) sqx_in = 64'(ax_ff) * 64'(ax_ff);
      if (cmd.sqy) sqy_in = 64'(ay_ff) * 64'(ay_ff);

      if (cmd.sum) begin
         ovf_in = sum65[64];
         n_in   = sum65[63:0];
         r_in   = '0;
         bit_in = 64'd1 << 62;
      end

      if (cmd.root) begin
         if (n_ff >= trial_r) begin
            n_in = n_ff - trial_r;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      if (cmd.eval) begin
         act_in   = 1'b1;
         climb_in = '0;
         unique case (req_ff.opcode)
            hgsg_pkg::OP_TICK: begin
               if (st_ff.phase == hgsg_pkg::PH_START) begin
                  if (near_start) st_in.phase = hgsg_pkg::PH_CIRCLE;
               end else if (st_ff.phase == hgsg_pkg::PH_CIRCLE) begin
                  st_in.cpos_e = hgsg_pkg::satc(hgsg_pkg::wide_type'(st_ff.cpos_e) +
                                 hgsg_pkg::wide_type'(st_ff.step_e));
                  st_in.cpos_n = hgsg_pkg::satc(hgsg_pkg::wide_type'(st_ff.cpos_n) +
                                 hgsg_pkg::wide_type'(st_ff.step_n));
                  st_in.cpos_a = hgsg_pkg::satc(hgsg_pkg::wide_type'(st_ff.cpos_a) +
                                 hgsg_pkg::wide_type'(st_ff.step_a));
                  climb_in = hgsg_pkg::sat32(hgsg_pkg::wide_type'(st_ff.step_a) *
                                             hgsg_pkg::TICK_RATE_HZ);
                  if (hgsg_pkg::mag(hgsg_pkg::wide_type'(st_ff.rstep)) > hgsg_pkg::MILLI_RAW)
                  begin
                     st_in.cur_rad = hgsg_pkg::sat32(hgsg_pkg::wide_type'(st_ff.cur_rad) +
                                     hgsg_pkg::wide_type'(st_ff.rstep));
                     if (near_stop_r && near_stop_a) begin
                        act_in   = 1'b0;
                        climb_in = '0;
                     end
                  end else if (hgsg_pkg::mag(hgsg_pkg::wide_type'(st_ff.step_a)) >
                               hgsg_pkg::TENTH_RAW) begin
                     if (near_stop_a) begin
                        act_in   = 1'b0;
                        climb_in = '0;
                     end
                  end
               end else begin
                  act_in = 1'b0;
               end
            end
            hgsg_pkg::OP_SETUP: begin
               st_in.cpos_e     = hgsg_pkg::satc(hgsg_pkg::wide_type'(req_ff.new_center_east));
               st_in.cpos_n     = hgsg_pkg::satc(hgsg_pkg::wide_type'(req_ff.new_center_north));
               st_in.cpos_a     = hgsg_pkg::satc(hgsg_pkg::wide_type'(cfg_ff.start_alt));
               st_in.held_start = cfg_ff.start_alt;
               st_in.held_stop  = cfg_ff.stop_alt;
               if (sign_bad) begin
                  st_in.phase = hgsg_pkg::PH_FAIL;
               end else begin
                  st_in.step_e   = cfg_ff.vel_e / hgsg_pkg::TICK_RATE_HZ;
                  st_in.step_n   = cfg_ff.vel_n / hgsg_pkg::TICK_RATE_HZ;
                  st_in.step_a   = cfg_ff.vel_u / hgsg_pkg::TICK_RATE_HZ;
                  st_in.cl_start = cl_start_v;
                  st_in.cur_rad  = cl_start_v;
                  st_in.cl_stop  = cl_stop_v;
                  st_in.phase    = hgsg_pkg::PH_START;
                  if (dr_small) begin
                     st_in.rstep = '0;
                  end else if (dz_small && vz_big) begin
                     st_in.step_a = '0;
                     st_in.rstep  = hgsg_pkg::sat32((dr_w < 0) ? -hgsg_pkg::mag(vq) :
                                                    hgsg_pkg::mag(vq));
                  end else if (!vz_big) begin
                     st_in.phase = hgsg_pkg::PH_FAIL;
                  end else if (dz_w == 0) begin
                     st_in.rstep = '0;
                  end
               end
            end
            hgsg_pkg::OP_CENTRE: begin
               st_in.cpos_e = hgsg_pkg::satc(hgsg_pkg::wide_type'(req_ff.new_center_east));
               st_in.cpos_n = hgsg_pkg::satc(hgsg_pkg::wide_type'(req_ff.new_center_north));
               st_in.step_e = req_ff.new_speed_east / hgsg_pkg::TICK_RATE_HZ;
               st_in.step_n = req_ff.new_speed_north / hgsg_pkg::TICK_RATE_HZ;
            end
            hgsg_pkg::OP_HSPEED: begin
               st_in.step_e = req_ff.new_speed_east / hgsg_pkg::TICK_RATE_HZ;
               st_in.step_n = req_ff.new_speed_north / hgsg_pkg::TICK_RATE_HZ;
            end
            hgsg_pkg::OP_VSPEED: begin
               st_in.step_a = req_ff.new_speed_up / hgsg_pkg::TICK_RATE_HZ;
            end
            default: act_in = 1'b0;
         endcase
      end

      if (cmd.mulr) prod_in = $signed(dr_w[31:0]) * cfg_ff.vel_u;

      if (cmd.dinit) begin
         quo_in = hgsg_pkg::mag(prod_ff);
         rem_in = '0;
         den_in = hgsg_pkg::DEN_W'(hgsg_pkg::mag(dz_w) * hgsg_pkg::TICK_RATE_HZ);
         neg_in = prod_ff[63] ^ dz_w[63];
      end

      if (cmd.dstep) begin
         if (trial_d >= {1'b0, den_ff}) begin
            rem_in = hgsg_pkg::DEN_W'(trial_d - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial_d[hgsg_pkg::DEN_W-1:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end

      if (cmd.dfin) st_in.rstep = hgsg_pkg::sat32(neg_ff ? -q_w : q_w);

      if (cmd.emit) begin
         rsp_in.active          = act_ff;
         rsp_in.failed          = (st_ff.phase == hgsg_pkg::PH_FAIL);
         rsp_in.circle_east     = hgsg_pkg::sat32(hgsg_pkg::wide_type'(st_ff.cpos_e));
         rsp_in.circle_north    = hgsg_pkg::sat32(hgsg_pkg::wide_type'(st_ff.cpos_n));
         rsp_in.circle_radius   = st_ff.cur_rad;
         rsp_in.target_altitude = hgsg_pkg::sat32(hgsg_pkg::wide_type'(st_ff.cpos_a));
         rsp_in.climb_rate      = climb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         st_ff  <= '0;
      end else begin
         cfg_ff <= cfg_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      big_ff   <= big_in;
      ovf_ff   <= ovf_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      n_ff     <= n_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      act_ff   <= act_in;
      climb_ff <= climb_in;
   end

   assign rsp_data = rsp_ff;

endmodule

### src/helix_guidance_setpoint_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helix_guidance_setpoint_generator
// Helix guidance: setup checks, centre and radius stepping, finish detection.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A tick passes
// through the 32-step bit-serial square root of the distance to the centre.
// A setup that needs the radius increment from the ratio of radius and
// altitude change passes through the 64-step radix-2 divider; other requests
// take neither. The next request is accepted as soon as the result sits in
// the output register. Registers are to be written through the csr channel
// only while idle; the block itself does not enforce this.
module helix_guidance_setpoint_generator (
   input logic        clock,
   input logic        reset,
   hgsg_req_if.sink   req_ch,
   hgsg_rsp_if.source rsp_ch,
   hgsg_csr_if.sink   csr_ch
);

   hgsg_pkg::cmd_type  cmd;
   hgsg_pkg::stat_type stat;
   hgsg_pkg::req_type  req_data;
   hgsg_pkg::rsp_type  rsp_data;
   hgsg_pkg::csr_type  csr_data;

   assign req_data.opcode           = req_ch.opcode;
   assign req_data.pos_east         = req_ch.pos_east;
   assign req_data.pos_north        = req_ch.pos_north;
   assign req_data.pos_altitude     = req_ch.pos_altitude;
   assign req_data.new_center_east  = req_ch.new_center_east;
   assign req_data.new_center_north = req_ch.new_center_north;
   assign req_data.new_speed_east   = req_ch.new_speed_east;
   assign req_data.new_speed_north  = req_ch.new_speed_north;
   assign req_data.new_speed_up     = req_ch.new_speed_up;

   assign csr_data.index = csr_ch.index;
   assign csr_data.data  = csr_ch.data;
   assign csr_ch.ready   = 1'b1;

   hgsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   hgsg_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .csr_we   (csr_ch.valid),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

   assign rsp_ch.active          = rsp_data.active;
   assign rsp_ch.failed          = rsp_data.failed;
   assign rsp_ch.circle_east     = rsp_data.circle_east;
   assign rsp_ch.circle_north    = rsp_data.circle_north;
   assign rsp_ch.circle_radius   = rsp_data.circle_radius;
   assign rsp_ch.target_altitude = rsp_data.target_altitude;
   assign rsp_ch.climb_rate      = rsp_data.climb_rate;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while busy");

   a_climb_only_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.climb_rate != 0) |-> rsp_ch.active)
      else $error("climb rate on inactive result");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (req_ch.ready && !rsp_ch.valid))
      else $error("not idle after reset");

endmodule

### tb/helix_guidance_setpoint_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// helix_guidance_setpoint_generator_tb
// Self-checking bench: a directed table of requests and register writes, then
// randomised phases of a setup and mixed requests, mostly ticks aimed at the
// start and stop circles. Each request is scored against its table entry or
// a helix predictor; random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module helix_guidance_setpoint_generator_tb;
   import hgsg_pkg::*;

   localparam longint M_RAW       = 65536;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam int     PHASES      = 13;

   typedef struct {
      bit         is_csr;
      logic [2:0] idx;
      logic [31:0] data;
      req_type    rq;
      bit         typed;
      rsp_type    ex;
   } dir_row_type;

   logic clock;
   logic reset;

   hgsg_req_if req_bus ();
   hgsg_rsp_if rsp_bus ();
   hgsg_csr_if csr_bus ();

   helix_guidance_setpoint_generator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // register copy
   longint c_start_alt, c_stop_alt, c_start_rad, c_stop_rad;
   longint c_vel_e, c_vel_n, c_vel_u;
   // guidance state copy
   logic [1:0] g_phase;
   longint g_centre [3];
   longint g_step [3];
   longint g_radius, g_start_rad_cl, g_stop_rad_cl, g_rad_step;
   longint g_hold_start_alt, g_hold_stop_alt;

   rsp_type     setpoint_q [$];
   dir_row_type dir_rows [$];
   int          errors;
   bit          quiet;
   bit          hold_req;
   longint      cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint mag64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint sat_s32(longint v);
      return (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
   endfunction

   function automatic longint sat_coord(longint v);
      return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint centre_distance(longint dx, longint dy);
      longint unsigned ax = longint'(mag64(dx));
      longint unsigned ay = longint'(mag64(dy));
      longint unsigned cap = 64'hFFFF_FFFF;
      longint unsigned sx, sy;
      if (ax > cap || ay > cap) return longint'(cap);
      sx = ax * ax;
      sy = ay * ay;
      if (sx > ~sy) return longint'(cap);
      return longint'(root64(sx + sy));
   endfunction

   function automatic rsp_type setpoint(bit act, longint climb);
      rsp_type o;
      o.active          = act;
      o.failed          = (g_phase == PH_FAIL);
      o.circle_east     = 32'(sat_s32(g_centre[0]));
      o.circle_north    = 32'(sat_s32(g_centre[1]));
      o.circle_radius   = 32'(sat_s32(g_radius));
      o.target_altitude = 32'(sat_s32(g_centre[2]));
      o.climb_rate      = 32'(sat_s32(climb));
      return o;
   endfunction

   function automatic void reset_guidance();
      c_start_alt = 0; c_stop_alt = 0; c_start_rad = 0; c_stop_rad = 0;
      c_vel_e = 0; c_vel_n = 0; c_vel_u = 0;
      g_phase = PH_START;
      for (int i = 0; i < 3; i++) begin
         g_centre[i] = 0;
         g_step[i] = 0;
      end
      g_radius = 0; g_start_rad_cl = 0; g_stop_rad_cl = 0; g_rad_step = 0;
      g_hold_start_alt = 0; g_hold_stop_alt = 0;
   endfunction

   function automatic void set_register(logic [2:0] idx, logic [31:0] d);
      case (idx)
         REG_START_ALT: c_start_alt = longint'($signed(d));
         REG_STOP_ALT:  c_stop_alt  = longint'($signed(d));
         REG_START_RAD: c_start_rad = longint'({33'd0, d[30:0]});
         REG_STOP_RAD:  c_stop_rad  = longint'({33'd0, d[30:0]});
         REG_VEL_EAST:  c_vel_e     = longint'($signed(d));
         REG_VEL_NORTH: c_vel_n     = longint'($signed(d));
         REG_VEL_UP:    c_vel_u     = longint'($signed(d));
         default: ;
      endcase
   endfunction

   function automatic void helix_setup(longint cx, longint cy);
      longint dz, dr, vz, m;
      vz = c_vel_u;
      g_centre[0] = sat_coord(cx);
      g_centre[1] = sat_coord(cy);
      g_centre[2] = sat_coord(c_start_alt);
      g_hold_start_alt = c_start_alt;
      g_hold_stop_alt = c_stop_alt;
      dz = c_stop_alt - c_start_alt;
      if (((dz < 0 && vz > 0) || (dz > 0 && vz < 0)) && mag64(dz) > ONE_RAW &&
          mag64(c_start_rad - c_stop_rad) > TENTH_RAW) begin
         g_phase = PH_FAIL;
         return;
      end
      g_step[0] = c_vel_e / TICK_RATE_HZ;
      g_step[1] = c_vel_n / TICK_RATE_HZ;
      g_step[2] = vz / TICK_RATE_HZ;
      g_start_rad_cl = (c_start_rad < MIN_RADIUS_RAW) ? MIN_RADIUS_RAW : c_start_rad;
      g_radius = g_start_rad_cl;
      g_stop_rad_cl = (c_stop_rad < MIN_RADIUS_RAW) ? MIN_RADIUS_RAW : c_stop_rad;
      dr = c_stop_rad - c_start_rad;
      if (mag64(dr) < ONE_RAW) begin
         g_rad_step = 0;
      end else if (mag64(dz) < ONE_RAW && mag64(vz) > TENTH_RAW) begin
         m = mag64(vz) / TICK_RATE_HZ;
         g_step[2] = 0;
         g_rad_step = sat_s32((dr < 0) ? -m : m);
      end else if (mag64(vz) <= TENTH_RAW) begin
         g_phase = PH_FAIL;
         return;
      end else if (dz != 0) begin
         g_rad_step = sat_s32((dr * vz) / (dz * TICK_RATE_HZ));
      end else begin
         g_rad_step = 0;
      end
      g_phase = PH_START;
   endfunction

   function automatic rsp_type helix_tick(req_type r);
      longint pe, pn, pa, dist_raw;
      pe = longint'(r.pos_east);
      pn = longint'(r.pos_north);
      pa = longint'(r.pos_altitude);
      dist_raw = centre_distance(pe - g_centre[0], pn - g_centre[1]);
      if (g_phase >= PH_FAIL) return setpoint(1'b0, 0);
      if (g_phase == PH_START) begin
         if (mag64(dist_raw - g_start_rad_cl) < TOL_RAW &&
             mag64(pa - g_hold_start_alt) < TOL_RAW)
            g_phase = PH_CIRCLE;
         return setpoint(1'b1, 0);
      end
      for (int i = 0; i < 3; i++) g_centre[i] = sat_coord(g_centre[i] + g_step[i]);
      if (mag64(g_rad_step) > MILLI_RAW) begin
         g_radius = sat_s32(g_radius + g_rad_step);
         if (mag64(dist_raw - g_stop_rad_cl) < TOL_RAW &&
             mag64(pa - g_hold_stop_alt) < TOL_RAW)
            return setpoint(1'b0, 0);
      end else if (mag64(g_step[2]) > TENTH_RAW) begin
         if (mag64(pa - g_hold_stop_alt) < TOL_RAW) return setpoint(1'b0, 0);
      end
      return setpoint(1'b1, g_step[2] * TICK_RATE_HZ);
   endfunction

   function automatic rsp_type predict_setpoint(req_type r);
      case (r.opcode)
         OP_TICK: return helix_tick(r);
         OP_SETUP: helix_setup(longint'(r.new_center_east), longint'(r.new_center_north));
         OP_CENTRE: begin
            g_centre[0] = sat_coord(longint'(r.new_center_east));
            g_centre[1] = sat_coord(longint'(r.new_center_north));
            g_step[0] = longint'(r.new_speed_east) / TICK_RATE_HZ;
            g_step[1] = longint'(r.new_speed_north) / TICK_RATE_HZ;
         end
         OP_HSPEED: begin
            g_step[0] = longint'(r.new_speed_east) / TICK_RATE_HZ;
            g_step[1] = longint'(r.new_speed_north) / TICK_RATE_HZ;
         end
         OP_VSPEED: g_step[2] = longint'(r.new_speed_up) / TICK_RATE_HZ;
         default: return setpoint(1'b0, 0);
      endcase
      return setpoint(1'b1, 0);
   endfunction

   function automatic req_type mk_req(logic [2:0] op, longint pe, longint pn, longint pa,
                                      longint ce, longint cn, longint se, longint sn,
                                      longint su);
      req_type r;
      r.opcode = op;
      r.pos_east = pe[31:0];
      r.pos_north = pn[31:0];
      r.pos_altitude = pa[31:0];
      r.new_center_east = ce[31:0];
      r.new_center_north = cn[31:0];
      r.new_speed_east = se[31:0];
      r.new_speed_north = sn[31:0];
      r.new_speed_up = su[31:0];
      return r;
   endfunction

   function automatic req_type full_random_req(logic [2:0] op);
      return mk_req(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
   endfunction

   task automatic issue(req_type r, bit use_typed, rsp_type typed);
      csr_bus.valid <= 1'b0;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= r.opcode;
      req_bus.pos_east <= r.pos_east;
      req_bus.pos_north <= r.pos_north;
      req_bus.pos_altitude <= r.pos_altitude;
      req_bus.new_center_east <= r.new_center_east;
      req_bus.new_center_north <= r.new_center_north;
      req_bus.new_speed_east <= r.new_speed_east;
      req_bus.new_speed_north <= r.new_speed_north;
      req_bus.new_speed_up <= r.new_speed_up;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      typed = use_typed ? typed : predict_setpoint(r);
      if (use_typed) void'(predict_setpoint(r));
      setpoint_q.push_back(typed);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (setpoint_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] d);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= d;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      set_register(idx, d);
   endtask

   function automatic longint pick_alt();
      case ($urandom_range(0, 6))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return 0;
         3: return longint'($signed($urandom));
         default: return (longint'($urandom_range(0, 2000)) - 1000) * M_RAW +
                         $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic longint pick_rad();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 64'h7FFF_FFFF;
         2: return longint'($urandom & 32'h7FFF_FFFF);
         default: return longint'($urandom_range(0, 500 * 65536));
      endcase
   endfunction

   function automatic longint pick_vel();
      case ($urandom_range(0, 8))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return 0;
         3: return longint'($urandom_range(0, 2 * 6553 + 8)) - 6557;
         4: return longint'($signed($urandom));
         default: return longint'($urandom_range(0, 20 * 65536)) - 10 * M_RAW;
      endcase
   endfunction

   function automatic longint jitter(bit near);
      return near ? longint'($urandom_range(0, 1200000)) - 600000
                  : longint'($urandom_range(0, 8000000)) - 4000000;
   endfunction

   function automatic req_type aimed_tick();
      longint rad, alt, off;
      bit near;
      near = ($urandom_range(0, 3) != 0);
      rad = (g_phase == PH_START) ? g_start_rad_cl : g_stop_rad_cl;
      alt = (g_phase == PH_START) ? g_hold_start_alt : g_hold_stop_alt;
      off = rad + jitter(near);
      if ($urandom_range(0, 1))
         return mk_req(OP_TICK, sat_s32(g_centre[0] + off), sat_s32(g_centre[1] + jitter(1)),
                       sat_s32(alt + jitter(near)), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      return mk_req(OP_TICK, sat_s32(g_centre[0] + jitter(1)), sat_s32(g_centre[1] - off),
                    sat_s32(alt + jitter(near)), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
   endfunction

   function automatic req_type random_req();
      int sel;
      longint ce, cn;
      sel = $urandom_range(0, 99);
      ce = longint'($urandom_range(0, 4000)) * M_RAW - 2000 * M_RAW;
      cn = longint'($urandom_range(0, 4000)) * M_RAW - 2000 * M_RAW;
      if (sel < 70) return aimed_tick();
      if (sel < 80) return full_random_req(OP_TICK);
      if (sel < 83) return mk_req(OP_SETUP, $urandom, $urandom, $urandom, ce, cn,
                                  $urandom, $urandom, $urandom);
      if (sel < 86) return mk_req(OP_CENTRE, $urandom, $urandom, $urandom, ce, cn,
                                  pick_vel(), pick_vel(), $urandom);
      if (sel < 89) return full_random_req(OP_HSPEED);
      if (sel < 92) return mk_req(OP_VSPEED, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, pick_vel());
      if (sel < 96) return full_random_req(3'($urandom_range(0, 4)));
      return full_random_req(3'($urandom_range(5, 7)));
   endfunction

   function automatic void put_req(req_type r);
      dir_row_type row;
      row = '{1'b0, 3'd0, 32'd0, r, 1'b0, '0};
      dir_rows.push_back(row);
   endfunction

   function automatic void put_typed(req_type r, rsp_type ex);
      dir_row_type row;
      row = '{1'b0, 3'd0, 32'd0, r, 1'b1, ex};
      dir_rows.push_back(row);
   endfunction

   function automatic void put_csr(logic [2:0] idx, longint d);
      dir_row_type row;
      row = '{1'b1, idx, d[31:0], '0, 1'b0, '0};
      dir_rows.push_back(row);
   endfunction

   function automatic void build_table();
      rsp_type idle_zero, run_zero;
      idle_zero = '{1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      run_zero  = '{1'b1, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      put_typed(mk_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), run_zero);
      put_typed(mk_req(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), idle_zero);
      put_typed(mk_req(3'd7, -1, -1, -1, -1, -1, -1, -1, -1), idle_zero);
      put_req(mk_req(OP_CENTRE, 0, 0, 0, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 0));
      put_req(mk_req(OP_HSPEED, 0, 0, 0, 0, 0, S32_MAX, S32_MIN, 0));
      put_req(mk_req(OP_VSPEED, 0, 0, 0, 0, 0, 0, 0, S32_MIN));
      put_req(mk_req(OP_TICK, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0, 0));
      // sign conflict between climb and altitude change
      put_csr(REG_START_ALT, 100 * M_RAW);
      put_csr(REG_STOP_ALT, 50 * M_RAW);
      put_csr(REG_START_RAD, 100 * M_RAW);
      put_csr(REG_STOP_RAD, 200 * M_RAW);
      put_csr(REG_VEL_UP, 2 * M_RAW);
      put_req(mk_req(OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // vertical speed too small
      put_csr(REG_VEL_UP, 0);
      put_req(mk_req(OP_SETUP, 0, 0, 0, 5 * M_RAW, 7 * M_RAW, 0, 0, 0));
      put_req(mk_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      // normal ratio, enter circle then finish at the stop circle
      put_csr(REG_VEL_UP, -2 * M_RAW);
      put_req(mk_req(OP_SETUP, 0, 0, 0, 10 * M_RAW, 20 * M_RAW, 0, 0, 0));
      put_req(mk_req(OP_TICK, 110 * M_RAW, 20 * M_RAW, 100 * M_RAW, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, 210 * M_RAW, 20 * M_RAW, 50 * M_RAW, 0, 0, 0, 0, 0));
      // level radius change
      put_csr(REG_STOP_ALT, 100 * M_RAW);
      put_csr(REG_VEL_UP, 2 * M_RAW);
      put_req(mk_req(OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, 0, 100 * M_RAW, 100 * M_RAW, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, 0, 200 * M_RAW, 100 * M_RAW, 0, 0, 0, 0, 0));
      // extremes everywhere
      put_csr(REG_START_ALT, S32_MIN);
      put_csr(REG_STOP_ALT, S32_MAX);
      put_csr(REG_START_RAD, 64'h7FFF_FFFF);
      put_csr(REG_STOP_RAD, 0);
      put_csr(REG_VEL_EAST, S32_MAX);
      put_csr(REG_VEL_NORTH, S32_MIN);
      put_csr(REG_VEL_UP, S32_MAX);
      put_req(mk_req(OP_SETUP, 0, 0, 0, S32_MAX, S32_MIN, 0, 0, 0));
      put_req(mk_req(OP_TICK, S32_MIN, S32_MAX, S32_MIN, 0, 0, 0, 0, 0));
      put_req(mk_req(OP_TICK, S32_MAX, S32_MIN, S32_MAX, 0, 0, 0, 0, 0));
   endfunction

   // result scoreboard
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.active, rsp_bus.failed, rsp_bus.circle_east, rsp_bus.circle_north,
                 rsp_bus.circle_radius, rsp_bus.target_altitude, rsp_bus.climb_rate};
         if (setpoint_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected setpoint %h", got);
         end else begin
            want = setpoint_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("setpoint mismatch: exp act %b fail %b e %h n %h r %h alt %h climb %h | got act %b fail %b e %h n %h r %h alt %h climb %h",
                           want.active, want.failed, want.circle_east, want.circle_north,
                           want.circle_radius, want.target_altitude, want.climb_rate,
                           got.active, got.failed, got.circle_east, got.circle_north,
                           got.circle_radius, got.target_altitude, got.climb_rate);
            end
         end
      end
   end

   // result side backpressure
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_bus.ready <= 1'b1;
         end else if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            n = 0;
            while (n < 400) begin
               @(posedge clock);
               n++;
            end
            hold_req = 1'b0;
         end else begin
            rsp_bus.ready <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_type none;
      int n_items;
      none = '0;
      errors = 0;
      quiet = 1'b0;
      hold_req = 1'b0;
      reset_guidance();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= OP_TICK;
      req_bus.pos_east <= '0;
      req_bus.pos_north <= '0;
      req_bus.pos_altitude <= '0;
      req_bus.new_center_east <= '0;
      req_bus.new_center_north <= '0;
      req_bus.new_speed_east <= '0;
      req_bus.new_speed_north <= '0;
      req_bus.new_speed_up <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_START_ALT;
      csr_bus.data <= '0;
      build_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) csr_write(dir_rows[i].idx, dir_rows[i].data);
         else issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ex);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1) quiet = 1'b1;
         csr_write(REG_START_ALT, 32'(pick_alt()));
         csr_write(REG_STOP_ALT, 32'(($urandom_range(0, 3) == 0) ? c_start_alt : pick_alt()));
         csr_write(REG_START_RAD, 32'(pick_rad()));
         csr_write(REG_STOP_RAD, 32'(($urandom_range(0, 4) == 0) ? c_start_rad : pick_rad()));
         csr_write(REG_VEL_EAST, 32'(pick_vel()));
         csr_write(REG_VEL_NORTH, 32'(pick_vel()));
         csr_write(REG_VEL_UP, 32'(pick_vel()));
         if (ph == 2) hold_req = 1'b1;
         issue(mk_req(OP_SETUP, $urandom, $urandom, $urandom,
                      longint'($urandom_range(0, 4000)) * M_RAW - 2000 * M_RAW,
                      longint'($urandom_range(0, 4000)) * M_RAW - 2000 * M_RAW,
                      $urandom, $urandom, $urandom), 1'b0, none);
         n_items = $urandom_range(110, 140);
         for (int k = 0; k < n_items; k++) issue(random_req(), 1'b0, none);
      end

      drain();
      repeat (100) @(posedge clock);
      if (setpoint_q.size() != 0) errors++;
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
